/* rtl/core/apmsd_pkg.sv */
package apmsd_pkg;

	// Field and register widths
	localparam int unsigned VERT_W       = 6;
	localparam int unsigned DIST_W       = 32;
	localparam int unsigned VCNT_W       = 7;
	localparam int unsigned PAIR_W       = 13;
	localparam int unsigned PAIR_OUT_W   = 12;
	localparam int unsigned S_DATA_W     = 48;
	localparam int unsigned M_DATA_W     = 48;

	// Defaults
	localparam int unsigned MAX_VERTICES_DEF = 64;
	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;
	localparam logic [DIST_W-1:0] DIST_INF   = {DIST_W{1'b1}};

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_R_IK,
		ST_R_AK,
		ST_R_RD,
		ST_R_UPD,
		ST_S_RD,
		ST_S_CHK,
		ST_S_ADD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} apmsd_state_t;

	// Shared add/compare unit result
	typedef struct packed {
		logic              carry;
		logic [DIST_W-1:0] sum;
		logic              lt;
	} alu_res_t;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* rtl/core/apmsd_ram.sv */
module apmsd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

/* rtl/core/apmsd_alu.sv */
module apmsd_alu (
	input  logic [apmsd_pkg::DIST_W-1:0] op_a,
	input  logic [apmsd_pkg::DIST_W-1:0] op_b,
	input  logic [apmsd_pkg::DIST_W-1:0] op_c,
	output apmsd_pkg::alu_res_t          res
);
	import apmsd_pkg::*;

	logic [DIST_W:0] sum_w;

	// a + b with carry out, and (a + b) < c on the low word
	always_comb begin
		sum_w     = {1'b0, op_a} + {1'b0, op_b};
		res.carry = sum_w[DIST_W];
		res.sum   = sum_w[DIST_W-1:0];
		res.lt    = (sum_w[DIST_W-1:0] < op_c);
	end

endmodule

/* rtl/core/apmsd_div.sv */
module apmsd_div #(
	parameter int unsigned NUM_W = 32,
	parameter int unsigned DEN_W = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     dividend,
	input  logic [DEN_W-1:0]     divisor,
	output logic [NUM_W-1:0]     quotient,
	output apmsd_pkg::div_stat_t stat
);
	import apmsd_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             take;

	// Restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		take  = (trial >= {1'b0, den_q});
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Shift register datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

/* rtl/core/all_pairs_mean_shortest_distance.sv */
// Edge load: each request reads the matrix, then compares and writes back.
// Last edge: relaxation over all (k, i, j) triples, then the sum over the pairs,
// both on the one add/compare unit, then the division; n = active count.
// After each result and after reset a clearing pass writes every matrix word,
// all 2^(2*ceil(log2 MAX_VERTICES)) of them (4096 by default); no edges taken meanwhile.
// Reset is asynchronous, active low; vertex_count resets to 64.
module all_pairs_mean_shortest_distance #(
	parameter int unsigned MAX_VERTICES = apmsd_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] source_vertex, [11:6] dest_vertex, [43:12] edge_cost, [47:44] zero
	input  logic [apmsd_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] mean_distance, [43:32] pair_count, [47:44] zero
	output logic [apmsd_pkg::M_DATA_W-1:0]    m_tdata,
	// [0] no_pairs
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [apmsd_pkg::VCNT_W-1:0]      cfg_data
);
	import apmsd_pkg::*;

	localparam int unsigned VW    = $clog2(MAX_VERTICES);
	localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
	localparam int unsigned AW    = 2 * VW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned NCW   = (CW > VCNT_W) ? CW : VCNT_W;
	localparam int unsigned LIMW  = 2 * CW;

	apmsd_state_t state_q, state_d;

	logic [VCNT_W-1:0] vcount_q;
	logic [NCW-1:0]    vc_ext;
	logic [NCW-1:0]    n_full;
	logic [CW-1:0]     n_act;
	logic [VW-1:0]     nm1;
	logic [LIMW-1:0]   limit_w;

	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     e_addr_q;
	logic [DIST_W-1:0] e_cost_q;
	logic              e_ok_q;
	logic              e_last_q;
	logic [VW-1:0]     k_q, i_q, j_q;
	logic [DIST_W-1:0] a_q, d_q, sum_q, limit_q;
	logic [PAIR_W-1:0] cnt_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic [VERT_W-1:0] in_src, in_dst;
	logic              in_ok;
	logic              accept;
	logic              j_last, i_last, k_last;
	logic              out_free;
	logic              relax_take, sum_take;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [DIST_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
	logic [DIST_W-1:0] alu_a, alu_b, alu_c;
	alu_res_t          alu_res;
	logic              div_start;
	logic [DIST_W-1:0] div_quo;
	div_stat_t         div_stat;

	// Active vertex count, saturated at MAX_VERTICES
	always_comb begin
		vc_ext  = NCW'(vcount_q);
		n_full  = (vc_ext > NCW'(MAX_VERTICES)) ? NCW'(MAX_VERTICES) : vc_ext;
		n_act   = CW'(n_full);
		nm1     = VW'(n_act - CW'(1));
		limit_w = LIMW'(n_act) * LIMW'(n_act);
	end

	// Input decode
	always_comb begin
		in_src = s_tdata[VERT_W-1:0];
		in_dst = s_tdata[2*VERT_W-1:VERT_W];
		in_ok  = (NCW'(in_src) < n_full) && (NCW'(in_dst) < n_full);
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign j_last    = (j_q == nm1);
	assign i_last    = (i_q == nm1);
	assign k_last    = (k_q == nm1);
	assign out_free  = !m_tvalid_q || m_tready;

	// Next state, memory and shared unit control
	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = {i_q, j_q};
		ram_wdata   = alu_res.sum;
		ram_raddr_a = {k_q, j_q};
		ram_raddr_b = {i_q, j_q};
		alu_a       = '0;
		alu_b       = '0;
		alu_c       = '0;
		div_start   = 1'b0;
		relax_take  = 1'b0;
		sum_take    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = (clr_addr_q[AW-1:VW] == clr_addr_q[VW-1:0]) ? '0 : DIST_INF;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_raddr_b = {VW'(in_src), VW'(in_dst)};
				if (accept) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				alu_a     = e_cost_q;
				alu_c     = ram_rdata_b;
				ram_waddr = e_addr_q;
				ram_we    = e_ok_q && alu_res.lt;
				if (!e_last_q) begin
					state_d = ST_IDLE;
				end else if (n_act == '0) begin
					state_d = ST_DIV_GO;
				end else begin
					state_d = ST_R_IK;
				end
			end
			ST_R_IK: begin
				ram_raddr_b = {i_q, k_q};
				state_d     = ST_R_AK;
			end
			ST_R_AK: begin
				state_d = ST_R_RD;
			end
			ST_R_RD: begin
				state_d = ST_R_UPD;
			end
			ST_R_UPD: begin
				alu_a      = a_q;
				alu_b      = ram_rdata_a;
				alu_c      = ram_rdata_b;
				relax_take = !alu_res.carry && alu_res.lt;
				ram_we     = relax_take;
				if (!j_last) begin
					state_d = ST_R_RD;
				end else if (!i_last || !k_last) begin
					state_d = ST_R_IK;
				end else begin
					state_d = ST_S_RD;
				end
			end
			ST_S_RD: begin
				state_d = ST_S_CHK;
			end
			ST_S_CHK: begin
				alu_b    = ram_rdata_b;
				alu_c    = limit_q;
				sum_take = (i_q != j_q) && alu_res.lt;
				if (sum_take) begin
					state_d = ST_S_ADD;
				end else if (j_last && i_last) begin
					state_d = ST_DIV_GO;
				end else begin
					state_d = ST_S_RD;
				end
			end
			ST_S_ADD: begin
				alu_a = sum_q;
				alu_b = d_q;
				if (j_last && i_last) begin
					state_d = ST_DIV_GO;
				end else begin
					state_d = ST_S_RD;
				end
			end
			ST_DIV_GO: begin
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Config register, sweep address, loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= VCNT_RESET;
			clr_addr_q <= '0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			cnt_q      <= '0;
			sum_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			// result valid: set on handoff, cleared once taken
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					k_q   <= '0;
					i_q   <= '0;
					j_q   <= '0;
					cnt_q <= '0;
					sum_q <= '0;
				end
				ST_R_UPD: begin
					if (!j_last) begin
						j_q <= j_q + VW'(1);
					end else begin
						j_q <= '0;
						if (!i_last) begin
							i_q <= i_q + VW'(1);
						end else begin
							i_q <= '0;
							if (!k_last) begin
								k_q <= k_q + VW'(1);
							end
						end
					end
				end
				ST_S_CHK, ST_S_ADD: begin
					if (state_q == ST_S_ADD) begin
						sum_q <= alu_res.sum;
						cnt_q <= cnt_q + PAIR_W'(1);
					end
					if (state_q == ST_S_ADD || !sum_take) begin
						if (!j_last) begin
							j_q <= j_q + VW'(1);
						end else begin
							j_q <= '0;
							i_q <= i_q + VW'(1);
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						clr_addr_q <= '0;
						cnt_q      <= '0;
						sum_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			e_addr_q <= {VW'(in_src), VW'(in_dst)};
			e_cost_q <= s_tdata[2*VERT_W+DIST_W-1:2*VERT_W];
			e_ok_q   <= in_ok;
			e_last_q <= s_tlast;
		end
		if (state_q == ST_LOAD) begin
			limit_q <= DIST_W'(limit_w);
		end
		if (state_q == ST_R_AK) begin
			a_q <= ram_rdata_b;
		end
		if (state_q == ST_S_CHK) begin
			d_q <= ram_rdata_b;
		end
		if (state_q == ST_FIN && out_free) begin
			if (cnt_q == '0) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b1;
			end else begin
				m_tdata_q <= M_DATA_W'({cnt_q[PAIR_OUT_W-1:0], div_quo});
				m_tuser_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Distance matrix
	apmsd_ram #(
		.WIDTH (DIST_W),
		.DEPTH (DEPTH)
	) u_matrix (
		.clk       (clk),
		.wr_en     (ram_we),
		.wr_addr   (ram_waddr),
		.wr_data   (ram_wdata),
		.rd_addr_a (ram_raddr_a),
		.rd_data_a (ram_rdata_a),
		.rd_addr_b (ram_raddr_b),
		.rd_data_b (ram_rdata_b)
	);

	// Shared add/compare unit
	apmsd_alu u_alu (
		.op_a (alu_a),
		.op_b (alu_b),
		.op_c (alu_c),
		.res  (alu_res)
	);

	// Mean divider
	apmsd_div #(
		.NUM_W (DIST_W),
		.DEN_W (PAIR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("matrix written while idle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (cnt_q != '0) && !div_stat.busy)
		else $error("divider started with zero count or while busy");

	a_plain_edge_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tlast) |=> !$rose(m_tvalid_q))
		else $error("result raised by a plain edge");

	a_no_pairs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> (m_tdata_q == '0))
		else $error("no_pairs result with nonzero payload");

endmodule

/* bench/mean_distance_checker.sv */
// Watches the edge, config and result channels, predicts the mean shortest
// distance of each loaded graph and compares it with what the block emits.
module mean_distance_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// [5:0] source_vertex, [11:6] dest_vertex, [43:12] edge_cost, [47:44] zero
	input  logic [apmsd_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] mean_distance, [43:32] pair_count, [47:44] zero
	input  logic [apmsd_pkg::M_DATA_W-1:0] m_tdata,
	// [0] no_pairs
	input  logic                           m_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [apmsd_pkg::VCNT_W-1:0]   cfg_data,
	output int                             fail_count,
	output int                             outstanding
);
	import apmsd_pkg::*;

	localparam int unsigned NV = MAX_VERTICES_DEF;

	typedef struct packed {
		logic [DIST_W-1:0]     mean;
		logic [PAIR_OUT_W-1:0] pairs;
		logic                  no_pairs;
	} mean_result_t;

	// Shadow copy of the block state
	logic [DIST_W-1:0] shadow_dist [NV*NV];
	logic [VCNT_W-1:0] vcount;
	mean_result_t      expected_means[$];
	mean_result_t      want;
	int                mismatches = 0;

	logic [VERT_W-1:0] src_v, dst_v;
	logic [DIST_W-1:0] cost_v;

	assign fail_count = mismatches;

	function automatic int unsigned active_vertices();
		return (vcount > NV) ? NV : int'(vcount);
	endfunction

	// All infinity, zero diagonal
	function automatic void wipe_distances();
		for (int unsigned c = 0; c < NV * NV; c++)
			shadow_dist[c] = DIST_INF;
		for (int unsigned r = 0; r < NV; r++)
			shadow_dist[r * NV + r] = '0;
	endfunction

	// Relax, sum the short pairs, divide, then clear the matrix
	function automatic mean_result_t solve_mean_distance();
		int unsigned       n, lim;
		logic [DIST_W:0]   path;
		logic [DIST_W-1:0] total, d;
		logic [PAIR_W-1:0] cnt;
		mean_result_t      r;
		n = active_vertices();
		for (int unsigned k = 0; k < n; k++)
			for (int unsigned i = 0; i < n; i++)
				for (int unsigned j = 0; j < n; j++) begin
					path = {1'b0, shadow_dist[i * NV + k]} + {1'b0, shadow_dist[k * NV + j]};
					// a carried sum never replaces an entry
					if (!path[DIST_W] && path[DIST_W-1:0] < shadow_dist[i * NV + j])
						shadow_dist[i * NV + j] = path[DIST_W-1:0];
				end
		lim = n * n;
		total = '0;
		cnt = '0;
		for (int unsigned i = 0; i < n; i++)
			for (int unsigned j = 0; j < n; j++) begin
				d = shadow_dist[i * NV + j];
				if (i != j && d < lim) begin
					total += d;
					cnt += 1'b1;
				end
			end
		if (cnt == '0) begin
			r.mean = '0;
			r.pairs = '0;
			r.no_pairs = 1'b1;
		end else begin
			r.mean = total / DIST_W'(cnt);
			r.pairs = cnt[PAIR_OUT_W-1:0];
			r.no_pairs = 1'b0;
		end
		wipe_distances();
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [DIST_W-1:0] got,
			input logic [DIST_W-1:0] exp_val);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_distances();
			vcount = VCNT_RESET;
			expected_means.delete();
			outstanding <= 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready)
				vcount = cfg_data;

			// edge request: keep the cheaper cost, solve on the last one
			if (s_tvalid && s_tready) begin
				src_v = s_tdata[5:0];
				dst_v = s_tdata[11:6];
				cost_v = s_tdata[43:12];
				if (src_v < active_vertices() && dst_v < active_vertices() &&
						cost_v < shadow_dist[src_v * NV + dst_v])
					shadow_dist[src_v * NV + dst_v] = cost_v;
				if (s_tlast)
					expected_means.push_back(solve_mean_distance());
			end

			// result request
			if (m_tvalid && m_tready) begin
				if (expected_means.size() == 0) begin
					note_mismatch("result with nothing pending", m_tdata[31:0], '0);
				end else begin
					want = expected_means.pop_front();
					if (m_tdata[31:0] !== want.mean)
						note_mismatch("mean_distance", m_tdata[31:0], want.mean);
					if (m_tdata[43:32] !== want.pairs)
						note_mismatch("pair_count", DIST_W'(m_tdata[43:32]),
							DIST_W'(want.pairs));
					if (m_tuser !== want.no_pairs)
						note_mismatch("no_pairs", DIST_W'(m_tuser), DIST_W'(want.no_pairs));
				end
			end

			outstanding <= expected_means.size();
		end
	end

endmodule

/* bench/all_pairs_mean_shortest_distance_tb.sv */
module all_pairs_mean_shortest_distance_tb;
	import apmsd_pkg::*;

	localparam int RANDOM_ITEMS = 2000;
	localparam int CYCLE_LIMIT  = 20000000;
	localparam int HOLD_CYCLES  = 40000;
	localparam int HOLD_FRAME   = 9;
	localparam int LOAD_SETTLE  = 4;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// [5:0] source_vertex, [11:6] dest_vertex, [43:12] edge_cost, [47:44] zero
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	// [31:0] mean_distance, [43:32] pair_count, [47:44] zero
	logic [M_DATA_W-1:0] m_tdata;
	// [0] no_pairs
	logic                m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [VCNT_W-1:0]   cfg_data;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int cur_count = VCNT_RESET;
	int random_items = 0;
	bit hold_armed = 0;
	bit hold_used = 0;
	int hold_left = 0;

	all_pairs_mean_shortest_distance uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mean_distance_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls plus one long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed && !hold_used) begin
				hold_used = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one edge; returns at the falling edge after it was taken
	task automatic push_edge(input int src, input int dst, input logic [DIST_W-1:0] cost,
			input bit last_flag);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, cost, VERT_W'(dst), VERT_W'(src)};
		s_tlast <= last_flag;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Register write once no result is pending
	task automatic set_vertex_count(input int value);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (LOAD_SETTLE) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= VCNT_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = value;
	endtask

	function automatic logic [DIST_W-1:0] draw_cost(input int n);
		case ($urandom_range(9))
			6: draw_cost = '0;
			7: draw_cost = $urandom;
			8: draw_cost = DIST_INF - $urandom_range(0, 255);
			9: draw_cost = 32'h8000_0000 ^ $urandom_range(0, 65535);
			default: draw_cost = $urandom_range(0, 2 * n + 2);
		endcase
	endfunction

	// Stimulus
	initial begin
		int n, edges, src, dst, frame_no, sel;
		bit do_cfg, shift_mid, keep_count;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-size graph at the reset count: vertex extremes, zero and
		// maximum cost, a carrying path, a large legal path, the n*n boundary
		push_edge(0, 1, 5, 0);
		push_edge(1, 2, 7, 0);
		push_edge(63, 0, 3, 0);
		push_edge(2, 63, 0, 0);
		push_edge(1, 2, 9, 0);
		push_edge(5, 6, DIST_INF, 0);
		push_edge(10, 11, 32'hFFFF_FFF0, 0);
		push_edge(11, 12, 32'h20, 0);
		push_edge(20, 21, 32'h8000_0000, 0);
		push_edge(21, 22, 32'h7FFF_FFFF, 0);
		set_vertex_count(64);
		push_edge(40, 41, 4095, 0);
		push_edge(42, 43, 4096, 0);
		// oversized count saturates
		set_vertex_count(127);
		push_edge(0, 0, 1, 0);
		push_edge(63, 63, 12, 1);

		// zero vertices: every edge ignored
		set_vertex_count(0);
		push_edge(0, 0, 0, 0);
		push_edge(1, 2, 3, 0);
		push_edge(0, 1, 1, 1);

		// one vertex: no distinct pair
		set_vertex_count(1);
		push_edge(0, 0, 5, 0);
		push_edge(0, 0, 2, 1);

		// out-of-range edges, last flag on an ignored edge
		set_vertex_count(3);
		push_edge(0, 1, 2, 0);
		push_edge(1, 2, 2, 0);
		push_edge(3, 0, 1, 0);
		push_edge(0, 3, 1, 0);
		push_edge(5, 1, 1, 1);

		// count shrinks and grows again during a load
		set_vertex_count(4);
		push_edge(3, 0, 1, 0);
		set_vertex_count(2);
		push_edge(0, 1, 1, 0);
		set_vertex_count(4);
		push_edge(1, 3, 1, 1);

		// Random graphs, mostly small, cycling through idle and stall phases
		frame_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ((frame_no / 5) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase

			// the two frames after the hold keep their count so edges pile up
			keep_count = (frame_no == HOLD_FRAME + 1) || (frame_no == HOLD_FRAME + 2);
			do_cfg = !keep_count && ($urandom_range(99) < 70);
			if (do_cfg) begin
				sel = $urandom_range(99);
				if (sel < 4)
					set_vertex_count(0);
				else if (sel < 8)
					set_vertex_count(1);
				else if (sel < 14)
					set_vertex_count($urandom_range(11, 16));
				else
					set_vertex_count($urandom_range(2, 10));
			end
			if (cur_count > 16 && !keep_count)
				set_vertex_count($urandom_range(2, 10));

			// receiver holds off once this frame's count is set
			if (frame_no == HOLD_FRAME)
				hold_armed = 1;

			shift_mid = !keep_count && ($urandom_range(99) < 8);
			edges = ($urandom_range(99) < 5) ? 1 : $urandom_range(4, 36);
			for (int e = 0; e < edges; e++) begin
				n = (cur_count > 64) ? 64 : cur_count;
				if (shift_mid && e == edges / 2)
					set_vertex_count($urandom_range(1, 12));
				if ($urandom_range(99) < 85 && n > 0) begin
					src = $urandom_range(0, n - 1);
					dst = $urandom_range(0, n - 1);
				end else begin
					src = $urandom_range(0, 63);
					dst = $urandom_range(0, 63);
				end
				push_edge(src, dst, draw_cost(n), e == edges - 1);
				random_items++;
			end
			frame_no++;
		end
		s_tvalid <= 1'b0;

		// drain, then leave room for anything stray
		while (outstanding != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
